// ===== src/blat_pkg.sv =====
// ----------------------------------------------------------------------------
// blat_pkg
// Shared sizes, codes, types and helpers for the binary-lifting ancestor
// table.
// ----------------------------------------------------------------------------
package blat_pkg;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 11;
    localparam int FIELD_W   = 10;
    localparam int NODE_W    = (NODES > 2) ? $clog2(NODES) : 1;
    localparam int DEPTH_W   = NODE_W;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ANC_DEPTH = NODES * LEVELS;
    localparam int ADDR_W    = $clog2(ANC_DEPTH);

    localparam logic [1:0] ACT_ATTACH = 2'd0;
    localparam logic [1:0] ACT_LCA    = 2'd1;
    localparam logic [1:0] ACT_KTH    = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_NONE = 1'b1;

    typedef struct packed {
        logic              present;
        logic [NODE_W-1:0] node;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_anc_req;

    typedef struct packed {
        logic               we;
        logic [NODE_W-1:0]  waddr;
        logic [DEPTH_W-1:0] wdata;
        logic [NODE_W-1:0]  raddr_a;
        logic [NODE_W-1:0]  raddr_b;
    } t_dep_req;

    // entry of (node, level) sits at node*LEVELS + level
    function automatic logic [ADDR_W-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                    input logic [LVL_W-1:0] level);
        return ADDR_W'(32'(node) * LEVELS + 32'(level));
    endfunction

    function automatic logic in_range(input logic [FIELD_W-1:0] x);
        return 32'(x) < NODES;
    endfunction

    function automatic logic bit_at(input logic [31:0] val, input logic [LVL_W-1:0] i);
        return val[i];
    endfunction

endpackage

// ===== src/blat_anc_mem.sv =====
// ----------------------------------------------------------------------------
// blat_anc_mem
// Ancestor table memory: one write port, two registered read ports, and a
// clearing sweep after reset that marks every entry absent.
// ----------------------------------------------------------------------------
module blat_anc_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blat_pkg::t_anc_req i_req,
    output blat_pkg::t_entry  o_rdata_a,
    output blat_pkg::t_entry  o_rdata_b,
    output logic              o_busy
);

    blat_pkg::t_entry mem [blat_pkg::ANC_DEPTH];

    logic                        r_busy;
    logic [blat_pkg::ADDR_W-1:0] r_clr;
    blat_pkg::t_entry            r_rd_a;
    blat_pkg::t_entry            r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            if (32'(r_clr) == blat_pkg::ANC_DEPTH - 1) begin
                r_busy <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr] <= '0;
        end else if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= mem[i_req.raddr_a];
        r_rd_b <= mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;
    assign o_busy    = r_busy;

endmodule

// ===== src/blat_dep_mem.sv =====
// ----------------------------------------------------------------------------
// blat_dep_mem
// Node depth memory: one write port, two registered read ports, no reset.
// ----------------------------------------------------------------------------
module blat_dep_mem (
    input  logic                         i_clk,
    input  blat_pkg::t_dep_req           i_req,
    output logic [blat_pkg::DEPTH_W-1:0] o_rdata_a,
    output logic [blat_pkg::DEPTH_W-1:0] o_rdata_b
);

    logic [blat_pkg::DEPTH_W-1:0] mem [blat_pkg::NODES];
    logic [blat_pkg::DEPTH_W-1:0] r_rd_a;
    logic [blat_pkg::DEPTH_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= mem[i_req.raddr_a];
        r_rd_b <= mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ===== src/binary_lifting_ancestor_table.sv =====
// Throughput: one word at a time, the next taken the cycle after the result loads;
// the sequencer walks the table level by level, dependent memory reads at each step.
// After reset a clearing pass over all NODES*LEVELS (11264) entries marks every
// entry absent; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// binary_lifting_ancestor_table
// Binary-lifting ancestor table with attach, LCA and k-th ancestor requests.
// ----------------------------------------------------------------------------
module binary_lifting_ancestor_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [blat_pkg::FIELD_W-1:0] i_node,
    input  logic [blat_pkg::FIELD_W-1:0] i_other,
    input  logic                         i_has_parent,
    input  logic [blat_pkg::FIELD_W-1:0] i_steps,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_status,
    output logic [blat_pkg::FIELD_W-1:0] o_answer_node
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_AT0  = 5'd1;
    localparam logic [4:0] S_ATD  = 5'd2;
    localparam logic [4:0] S_ATR  = 5'd3;
    localparam logic [4:0] S_ATW  = 5'd4;
    localparam logic [4:0] S_LD   = 5'd5;
    localparam logic [4:0] S_LC   = 5'd6;
    localparam logic [4:0] S_LLR  = 5'd7;
    localparam logic [4:0] S_LLW  = 5'd8;
    localparam logic [4:0] S_LEQ  = 5'd9;
    localparam logic [4:0] S_LJR  = 5'd10;
    localparam logic [4:0] S_LJC  = 5'd11;
    localparam logic [4:0] S_LFR  = 5'd12;
    localparam logic [4:0] S_LFC  = 5'd13;
    localparam logic [4:0] S_KR   = 5'd14;
    localparam logic [4:0] S_KW   = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    localparam logic [blat_pkg::LVL_W-1:0] LVL_TOP = blat_pkg::LVL_W'(blat_pkg::LEVELS - 1);

    logic [4:0]                   r_state, n_state;
    logic [blat_pkg::LVL_W-1:0]   r_lvl, n_lvl;
    logic [blat_pkg::NODE_W-1:0]  r_u, n_u;
    logic [blat_pkg::NODE_W-1:0]  r_v, n_v;
    blat_pkg::t_entry             r_cur, n_cur;
    logic [blat_pkg::DEPTH_W-1:0] r_diff, n_diff;
    logic [blat_pkg::FIELD_W-1:0] r_steps, n_steps;
    logic                         r_hasp, n_hasp;
    logic                         r_res_status, n_res_status;
    logic [blat_pkg::FIELD_W-1:0] r_res_node, n_res_node;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_status, n_out_status;
    logic [blat_pkg::FIELD_W-1:0] r_out_node, n_out_node;

    blat_pkg::t_anc_req           anc_req;
    blat_pkg::t_dep_req           dep_req;
    blat_pkg::t_entry             anc_a, anc_b;
    logic [blat_pkg::DEPTH_W-1:0] dep_a, dep_b;
    logic [blat_pkg::DEPTH_W-1:0] dep_inc;
    logic                         clr_busy;
    logic                         in_acc;

    blat_anc_mem u_anc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (anc_req),
        .o_rdata_a (anc_a),
        .o_rdata_b (anc_b),
        .o_busy    (clr_busy)
    );

    blat_dep_mem u_dep (
        .i_clk     (i_clk),
        .i_req     (dep_req),
        .o_rdata_a (dep_a),
        .o_rdata_b (dep_b)
    );

    assign o_in_stall = (r_state != S_IDLE) || clr_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    // child depth, saturating at the deepest representable level
    assign dep_inc = (32'(dep_a) >= blat_pkg::NODES - 1) ?
                     blat_pkg::DEPTH_W'(blat_pkg::NODES - 1) : dep_a + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_lvl        = r_lvl;
        n_u          = r_u;
        n_v          = r_v;
        n_cur        = r_cur;
        n_diff       = r_diff;
        n_steps      = r_steps;
        n_hasp       = r_hasp;
        n_res_status = r_res_status;
        n_res_node   = r_res_node;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_node   = r_out_node;
        anc_req      = '0;
        dep_req      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_u          = blat_pkg::NODE_W'(i_node);
                    n_v          = blat_pkg::NODE_W'(i_other);
                    n_hasp       = i_has_parent;
                    n_steps      = i_steps;
                    n_res_status = blat_pkg::ST_NONE;
                    n_res_node   = '0;
                    n_lvl        = '0;
                    case (i_action)
                        blat_pkg::ACT_ATTACH: begin
                            if (!blat_pkg::in_range(i_node) ||
                                (i_has_parent && !blat_pkg::in_range(i_other))) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_AT0;
                            end
                        end
                        blat_pkg::ACT_LCA: begin
                            if (!blat_pkg::in_range(i_node) ||
                                !blat_pkg::in_range(i_other)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_LD;
                            end
                        end
                        blat_pkg::ACT_KTH: begin
                            if (!blat_pkg::in_range(i_node) ||
                                ((32'(i_steps) >> blat_pkg::LEVELS) != 32'd0)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_KR;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // attach: level 0 entry and parent depth lookup
            S_AT0: begin
                dep_req.raddr_a = r_v;
                anc_req.we      = 1'b1;
                anc_req.waddr   = blat_pkg::anc_addr(r_u, '0);
                anc_req.wdata   = r_hasp ? {1'b1, r_v} : '0;
                n_cur           = r_hasp ? {1'b1, r_v} : '0;
                n_lvl           = blat_pkg::LVL_W'(1);
                n_state         = S_ATD;
            end
            S_ATD: begin
                dep_req.we    = 1'b1;
                dep_req.waddr = r_u;
                dep_req.wdata = r_hasp ? dep_inc : '0;
                n_state       = S_ATR;
            end
            S_ATR: begin
                if (r_cur.present) begin
                    anc_req.raddr_a = blat_pkg::anc_addr(r_cur.node, r_lvl - 1'b1);
                    n_state         = S_ATW;
                end else begin
                    anc_req.we    = 1'b1;
                    anc_req.waddr = blat_pkg::anc_addr(r_u, r_lvl);
                    anc_req.wdata = '0;
                    if (r_lvl == LVL_TOP) begin
                        n_res_status = blat_pkg::ST_OK;
                        n_state      = S_DONE;
                    end else begin
                        n_lvl = r_lvl + 1'b1;
                    end
                end
            end
            S_ATW: begin
                anc_req.we    = 1'b1;
                anc_req.waddr = blat_pkg::anc_addr(r_u, r_lvl);
                anc_req.wdata = anc_a;
                n_cur         = anc_a;
                if (r_lvl == LVL_TOP) begin
                    n_res_status = blat_pkg::ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_ATR;
                end
            end

            // LCA: fetch both depths, put the deeper node in u
            S_LD: begin
                dep_req.raddr_a = r_u;
                dep_req.raddr_b = r_v;
                n_state         = S_LC;
            end
            S_LC: begin
                if (dep_a < dep_b) begin
                    n_u    = r_v;
                    n_v    = r_u;
                    n_diff = dep_b - dep_a;
                end else begin
                    n_diff = dep_a - dep_b;
                end
                n_lvl   = LVL_TOP;
                n_state = S_LLR;
            end
            S_LLR: begin
                if (blat_pkg::bit_at(32'(r_diff), r_lvl)) begin
                    anc_req.raddr_a = blat_pkg::anc_addr(r_u, r_lvl);
                    n_state         = S_LLW;
                end else if (r_lvl == '0) begin
                    n_state = S_LEQ;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            S_LLW: begin
                if (!anc_a.present) begin
                    n_state = S_DONE;
                end else begin
                    n_u = anc_a.node;
                    if (r_lvl == '0) begin
                        n_state = S_LEQ;
                    end else begin
                        n_lvl   = r_lvl - 1'b1;
                        n_state = S_LLR;
                    end
                end
            end
            S_LEQ: begin
                if (r_u == r_v) begin
                    n_res_status = blat_pkg::ST_OK;
                    n_res_node   = blat_pkg::FIELD_W'(r_u);
                    n_state      = S_DONE;
                end else begin
                    n_lvl   = LVL_TOP;
                    n_state = S_LJR;
                end
            end
            S_LJR: begin
                anc_req.raddr_a = blat_pkg::anc_addr(r_u, r_lvl);
                anc_req.raddr_b = blat_pkg::anc_addr(r_v, r_lvl);
                n_state         = S_LJC;
            end
            S_LJC: begin
                if (anc_a.present && anc_b.present && (anc_a.node != anc_b.node)) begin
                    n_u = anc_a.node;
                    n_v = anc_b.node;
                end
                if (r_lvl == '0) begin
                    n_state = S_LFR;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = S_LJR;
                end
            end
            S_LFR: begin
                anc_req.raddr_a = blat_pkg::anc_addr(r_u, '0);
                n_state         = S_LFC;
            end
            S_LFC: begin
                // pair with no common parent lies in different trees
                if (anc_a.present) begin
                    n_res_status = blat_pkg::ST_OK;
                    n_res_node   = blat_pkg::FIELD_W'(anc_a.node);
                end
                n_state = S_DONE;
            end

            // k-th ancestor: climb by the set bits of steps, low level first
            S_KR: begin
                if (blat_pkg::bit_at(32'(r_steps), r_lvl)) begin
                    anc_req.raddr_a = blat_pkg::anc_addr(r_u, r_lvl);
                    n_state         = S_KW;
                end else if (r_lvl == LVL_TOP) begin
                    n_res_status = blat_pkg::ST_OK;
                    n_res_node   = blat_pkg::FIELD_W'(r_u);
                    n_state      = S_DONE;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            S_KW: begin
                if (!anc_a.present) begin
                    n_state = S_DONE;
                end else begin
                    n_u = anc_a.node;
                    if (r_lvl == LVL_TOP) begin
                        n_res_status = blat_pkg::ST_OK;
                        n_res_node   = blat_pkg::FIELD_W'(anc_a.node);
                        n_state      = S_DONE;
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_state = S_KR;
                    end
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_node   = r_res_node;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl        <= n_lvl;
        r_u          <= n_u;
        r_v          <= n_v;
        r_cur        <= n_cur;
        r_diff       <= n_diff;
        r_steps      <= n_steps;
        r_hasp       <= n_hasp;
        r_res_status <= n_res_status;
        r_res_node   <= n_res_node;
        r_out_status <= n_out_status;
        r_out_node   <= n_out_node;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_answer_node = r_out_node;

endmodule

// ===== sim/binary_lifting_ancestor_table_test.sv =====
// ----------------------------------------------------------------------------
// binary_lifting_ancestor_table_test
// Drives attach, LCA and k-th ancestor words into the ancestor table and
// checks every answer against a predictor that keeps its own tree tables.
// Random traffic builds forests and then one deep chain that saturates the
// depth, under several idling and stalling regimes.
// ----------------------------------------------------------------------------
module binary_lifting_ancestor_table_test;

    localparam logic [1:0] ACT_BAD = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]                   action;
        logic [blat_pkg::FIELD_W-1:0] node;
        logic [blat_pkg::FIELD_W-1:0] other;
        logic                         has_parent;
        logic [blat_pkg::FIELD_W-1:0] steps;
        logic                         status;
        logic [blat_pkg::FIELD_W-1:0] answer;
    } t_request;

    typedef struct {
        logic                         status;
        logic [blat_pkg::FIELD_W-1:0] answer;
    } t_answer;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [1:0]                   action = '0;
    logic [blat_pkg::FIELD_W-1:0] node = '0;
    logic [blat_pkg::FIELD_W-1:0] other = '0;
    logic                         has_parent = 1'b0;
    logic [blat_pkg::FIELD_W-1:0] steps = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         status;
    logic [blat_pkg::FIELD_W-1:0] answer_node;

    // predictor state
    bit                           anc_ok [blat_pkg::NODES][blat_pkg::LEVELS];
    bit [blat_pkg::NODE_W-1:0]    anc_up [blat_pkg::NODES][blat_pkg::LEVELS];
    bit [blat_pkg::DEPTH_W-1:0]   node_dep [blat_pkg::NODES];
    bit                           known [blat_pkg::NODES];
    int                           live_nodes[$];

    t_request                     request_q[$];
    t_answer                      answer_q[$];
    logic                         in_took = 1'b0;
    int                           mismatches = 0;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    int                           hold_req = 0;
    int                           hold_seen = 0;
    int                           hold_left = 0;

    binary_lifting_ancestor_table i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (action),
        .i_node        (node),
        .i_other       (other),
        .i_has_parent  (has_parent),
        .i_steps       (steps),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_answer_node (answer_node)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void resolve_request(inout t_request r);
        int u;
        int v;
        int t;
        int d;
        int diff;
        int p;
        r.status = blat_pkg::ST_NONE;
        r.answer = '0;
        case (r.action)
            blat_pkg::ACT_ATTACH: begin
                if (r.node >= blat_pkg::NODES ||
                    (r.has_parent && r.other >= blat_pkg::NODES))
                    return;
                u = int'(r.node);
                if (r.has_parent) begin
                    d = int'(node_dep[r.other]);
                    node_dep[u] = blat_pkg::DEPTH_W'((d >= blat_pkg::NODES - 1) ?
                                                     blat_pkg::NODES - 1 : d + 1);
                    anc_ok[u][0] = 1'b1;
                    anc_up[u][0] = blat_pkg::NODE_W'(r.other);
                end else begin
                    node_dep[u] = '0;
                    anc_ok[u][0] = 1'b0;
                    anc_up[u][0] = '0;
                end
                // level i is read after level i-1 of this node is rewritten
                for (int i = 1; i < blat_pkg::LEVELS; i++) begin
                    if (anc_ok[u][i-1]) begin
                        p = int'(anc_up[u][i-1]);
                        anc_ok[u][i] = anc_ok[p][i-1];
                        anc_up[u][i] = anc_up[p][i-1];
                    end else begin
                        anc_ok[u][i] = 1'b0;
                        anc_up[u][i] = '0;
                    end
                end
                if (!known[u]) begin
                    known[u] = 1'b1;
                    live_nodes.insert(live_nodes.size(), u);
                end
                r.status = blat_pkg::ST_OK;
            end
            blat_pkg::ACT_LCA: begin
                if (r.node >= blat_pkg::NODES || r.other >= blat_pkg::NODES)
                    return;
                u = int'(r.node);
                v = int'(r.other);
                if (node_dep[u] < node_dep[v]) begin
                    t = u;
                    u = v;
                    v = t;
                end
                diff = int'(node_dep[u]) - int'(node_dep[v]);
                for (int i = blat_pkg::LEVELS - 1; i >= 0; i--) begin
                    if ((diff >> i) & 1) begin
                        if (!anc_ok[u][i])
                            return;
                        u = int'(anc_up[u][i]);
                    end
                end
                if (u == v) begin
                    r.status = blat_pkg::ST_OK;
                    r.answer = blat_pkg::FIELD_W'(u);
                    return;
                end
                for (int i = blat_pkg::LEVELS - 1; i >= 0; i--) begin
                    if (anc_ok[u][i] && anc_ok[v][i] && anc_up[u][i] != anc_up[v][i]) begin
                        t = int'(anc_up[u][i]);
                        v = int'(anc_up[v][i]);
                        u = t;
                    end
                end
                if (anc_ok[u][0]) begin
                    r.status = blat_pkg::ST_OK;
                    r.answer = blat_pkg::FIELD_W'(anc_up[u][0]);
                end
            end
            blat_pkg::ACT_KTH: begin
                if (r.node >= blat_pkg::NODES || (int'(r.steps) >> blat_pkg::LEVELS) != 0)
                    return;
                u = int'(r.node);
                for (int i = 0; i < blat_pkg::LEVELS; i++) begin
                    if ((int'(r.steps) >> i) & 1) begin
                        if (!anc_ok[u][i])
                            return;
                        u = int'(anc_up[u][i]);
                    end
                end
                r.status = blat_pkg::ST_OK;
                r.answer = blat_pkg::FIELD_W'(u);
            end
            default: ;
        endcase
    endfunction

    function automatic void add_request(int act, int n, int o, int hp, int s);
        t_request r;
        r.action = 2'(act);
        r.node = blat_pkg::FIELD_W'(n);
        r.other = blat_pkg::FIELD_W'(o);
        r.has_parent = 1'(hp);
        r.steps = blat_pkg::FIELD_W'(s);
        resolve_request(r);
        request_q.insert(request_q.size(), r);
    endfunction

    function automatic int pick_live();
        return live_nodes[$urandom_range(0, live_nodes.size() - 1)];
    endfunction

    function automatic int any_field();
        return $urandom_range(0, (1 << blat_pkg::FIELD_W) - 1);
    endfunction

    // climbs mostly around the node's own depth, sometimes anywhere
    function automatic int climb_for(int n);
        int sel;
        int top;
        sel = $urandom_range(0, 3);
        top = int'(node_dep[n]) + 1;
        if (top > (1 << blat_pkg::FIELD_W) - 1)
            top = (1 << blat_pkg::FIELD_W) - 1;
        if (known[n] && sel < 2)
            return $urandom_range(0, top);
        if (sel == 2)
            return $urandom_range(0, 15);
        return any_field();
    endfunction

    function automatic void add_forest_request();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (live_nodes.size() == 0 || sel < 35) begin
            n = (sel < 10 && live_nodes.size() > 0) ? pick_live() : any_field();
            if (live_nodes.size() > 0 && $urandom_range(0, 9) != 0)
                add_request(blat_pkg::ACT_ATTACH, n, pick_live(), 1, any_field());
            else
                add_request(blat_pkg::ACT_ATTACH, n, any_field(), 0, any_field());
        end else if (sel < 60) begin
            n = pick_live();
            add_request(blat_pkg::ACT_LCA, n, ($urandom_range(0, 7) == 0) ? n : pick_live(),
                        $urandom_range(0, 1), any_field());
        end else if (sel < 85) begin
            n = ($urandom_range(0, 3) == 0) ? any_field() : pick_live();
            add_request(blat_pkg::ACT_KTH, n, any_field(), $urandom_range(0, 1),
                        climb_for(n));
        end else if (sel < 90) begin
            add_request(ACT_BAD, any_field(), any_field(), $urandom_range(0, 1), any_field());
        end else if (sel < 95) begin
            n = pick_live();
            add_request(blat_pkg::ACT_ATTACH, n, n, 1, any_field());
        end else begin
            add_request(blat_pkg::ACT_KTH, any_field(), any_field(), $urandom_range(0, 1),
                        any_field());
        end
    endfunction

    task automatic wait_drained();
        while (request_q.size() != 0 || answer_q.size() != 0)
            @(posedge clk);
    endtask

    // input side: acceptance bookkeeping and answer checking at the rising edge
    always @(posedge clk) begin
        t_answer want;
        t_answer pend;
        in_took <= in_valid && !in_stall;
        if (in_valid && !in_stall) begin
            pend.status = request_q[0].status;
            pend.answer = request_q[0].answer;
            answer_q.insert(answer_q.size(), pend);
            void'(request_q.pop_front());
        end
        if (out_valid && !out_stall) begin
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("answer with no request pending: status %0d node %0d",
                             status, answer_node);
            end else begin
                want = answer_q.pop_front();
                if (status !== want.status || answer_node !== want.answer) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("answer mismatch: expected status %0d node %0d, got %0d %0d",
                                 want.status, want.answer, status, answer_node);
                end
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                action     <= request_q[0].action;
                node       <= request_q[0].node;
                other      <= request_q[0].other;
                has_parent <= request_q[0].has_parent;
                steps      <= request_q[0].steps;
                in_valid   <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        int order[blat_pkg::NODES];
        int j;
        int t;
        int tail;
        int idx;
        int links;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero steps and past the root on an empty table, bad action
        add_request(blat_pkg::ACT_KTH, 0, 0, 0, 0);
        add_request(blat_pkg::ACT_KTH, 1023, 1023, 1, 1);
        add_request(ACT_BAD, 1023, 1023, 1, 1023);
        // small tree 0 -> 1 -> 2 -> 1023, 0 -> 3
        add_request(blat_pkg::ACT_ATTACH, 0, 1023, 0, 1023);
        add_request(blat_pkg::ACT_ATTACH, 1, 0, 1, 0);
        add_request(blat_pkg::ACT_ATTACH, 2, 1, 1, 0);
        add_request(blat_pkg::ACT_ATTACH, 1023, 2, 1, 0);
        add_request(blat_pkg::ACT_ATTACH, 3, 0, 1, 0);
        add_request(blat_pkg::ACT_LCA, 1023, 3, 0, 0);
        add_request(blat_pkg::ACT_LCA, 2, 1023, 0, 0);
        add_request(blat_pkg::ACT_LCA, 1023, 1023, 1, 1023);
        add_request(blat_pkg::ACT_KTH, 1023, 0, 0, 3);
        add_request(blat_pkg::ACT_KTH, 1023, 0, 0, 4);
        add_request(blat_pkg::ACT_KTH, 1023, 0, 0, 1023);
        // second tree, queries across trees
        add_request(blat_pkg::ACT_ATTACH, 512, 0, 0, 0);
        add_request(blat_pkg::ACT_LCA, 512, 1023, 0, 0);
        add_request(blat_pkg::ACT_ATTACH, 513, 512, 1, 0);
        add_request(blat_pkg::ACT_LCA, 1023, 513, 0, 0);
        // re-rooting 1 leaves stale entries below it: leveling meets an absent entry
        add_request(blat_pkg::ACT_ATTACH, 1, 1023, 0, 0);
        add_request(blat_pkg::ACT_LCA, 1023, 1, 0, 0);
        add_request(blat_pkg::ACT_LCA, 2, 3, 0, 0);
        add_request(blat_pkg::ACT_ATTACH, 2, 512, 1, 0);
        add_request(blat_pkg::ACT_KTH, 1023, 0, 0, 2);
        // self parent: every level points back at the node
        add_request(blat_pkg::ACT_ATTACH, 3, 3, 1, 0);
        add_request(blat_pkg::ACT_KTH, 3, 0, 0, 1023);
        wait_drained();

        repeat (150) add_forest_request();
        wait_drained();

        send_idle_pct = 61;
        repeat (150) add_forest_request();
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 61;
        repeat (150) add_forest_request();
        while (request_q.size() > 140)
            @(posedge clk);
        hold_req = hold_req + 1;
        wait_drained();

        // one deep chain through every node, then past the depth limit
        send_idle_pct = 20;
        recv_stall_pct = 20;
        for (int i = 0; i < blat_pkg::NODES; i++)
            order[i] = i;
        for (int i = blat_pkg::NODES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        tail = order[0];
        add_request(blat_pkg::ACT_ATTACH, tail, any_field(), 0, any_field());
        idx = 1;
        links = 1;
        while (links < blat_pkg::NODES + 16) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 1))
                    add_request(blat_pkg::ACT_LCA, tail, pick_live(), $urandom_range(0, 1),
                                any_field());
                else
                    add_request(blat_pkg::ACT_KTH, tail, any_field(), $urandom_range(0, 1),
                                climb_for(tail));
            end else begin
                t = (idx < blat_pkg::NODES) ? order[idx] :
                                              $urandom_range(0, blat_pkg::NODES - 1);
                idx++;
                add_request(blat_pkg::ACT_ATTACH, t, tail, 1, any_field());
                tail = t;
                links++;
            end
        end
        wait_drained();

        repeat (100) @(posedge clk);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
